// ===== design/gtd_pkg.sv =====
// shared constants, types and control codes of the goertzel tone detector
package gtd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEFF_W       = 17;
    localparam int COEFF_FRAC    = 14;
    localparam int LEN_W         = 13;
    localparam int POWER_W       = 48;
    localparam int ACC_W         = 40;
    localparam int MAX_BLOCK_LEN = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // digit-serial multiply-accumulate geometry
    localparam int DIGIT_W     = 5;
    localparam int COEFF_DIG   = (COEFF_W + DIGIT_W - 1) / DIGIT_W;
    localparam int COEFF_SER_W = COEFF_DIG * DIGIT_W;
    localparam int ACC_DIG     = ACC_W / DIGIT_W;
    localparam int SER_W       = 2 * ACC_W;
    localparam int MCAND_W     = ACC_W + COEFF_W + 1;
    localparam int PP_W        = MCAND_W + DIGIT_W + 1;
    localparam int PROD_W      = 2 * ACC_W + COEFF_W + 3;
    localparam int RPROD_W     = ACC_W + COEFF_W;
    localparam int POWER_SHIFT = 46;
    localparam int OFF_SHIFT   = 16;
    localparam int STEP_W      = 4;

    localparam logic [COEFF_SER_W-1:0] OFF_SCALE = COEFF_SER_W'(45875);

    localparam logic [STEP_W-1:0] COEFF_LAST = STEP_W'(COEFF_DIG - 1);
    localparam logic [STEP_W-1:0] PAIR_LAST  = STEP_W'(2 * ACC_DIG - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF     = 2'd0,
        CFG_BLOCK_LEN = 2'd1,
        CFG_ON_THR    = 2'd2
    } gtd_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC,
        ST_SUM,
        ST_CROSS,
        ST_TERM,
        ST_POWER,
        ST_CLAMP,
        ST_OFF,
        ST_DECIDE
    } gtd_state_t;

    // multiplicand source of the shared unit
    typedef enum logic [2:0] {
        MC_S1,
        MC_S2,
        MC_T,
        MC_U,
        MC_THR
    } gtd_mc_t;

    // multiplier digit source loaded into the shift register
    typedef enum logic [1:0] {
        LD_COEFF,
        LD_PAIR,
        LD_SCALE
    } gtd_load_t;

    typedef struct packed {
        logic in_ready;
        logic mac_load;
        gtd_load_t load_sel;
        logic mac_step;
        logic acc_shift;
        logic digit_signed;
        gtd_mc_t mc_sel;
        logic do_sum;
        logic do_term;
        logic do_clamp;
        logic do_decide;
    } gtd_ctl_t;

endpackage

// ===== design/gtd_if.sv =====
// handshake interfaces for the sample stream and the detection results
interface gtd_pcm_if import gtd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;

    modport source (output valid, sample, restart, input ready);
    modport sink (input valid, sample, restart, output ready);
endinterface

interface gtd_report_if import gtd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               tone_on;
    logic [POWER_W-1:0] block_power;

    modport source (output valid, tone_on, block_power, input ready);
    modport sink (input valid, tone_on, block_power, output ready);
endinterface

// ===== design/goertzel_tone_detector_hysteresis_core.sv =====
// top level of the goertzel tone detector with hysteresis flag
//
// usage: samples come in on the pcm channel (signed 16-bit sample plus a
// restart bit that clears the recurrence, the block count and the flag
// before the sample is used). one result per finished block leaves on the
// report channel: the hysteresis flag and the bin power shifted right 46.
// configuration (coefficient, block length, on threshold) is written over
// cfg_we/cfg_index/cfg_data while no sample is in flight.
//
// timing: all products go through one digit-serial multiply-accumulate
// unit, 5 multiplier bits per cycle. a sample that does not end a block
// goes through accept, the coefficient digits and the update. a sample that
// ends a block then goes through coeff*s2, a setup step, the interleaved
// power products, a clamp, the 0.7 off threshold and the decision.
// one sample is in work at a time; ready is high only between samples.
//
// the result sits in an output register; a stalled receiver only holds
// the block when a new result is due while the old one is still waiting.
// reset restores register defaults and clears the recurrence and flag.
module goertzel_tone_detector_hysteresis_core import gtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gtd_pcm_if.sink               pcm,
    gtd_report_if.source          report
);

    localparam int S0_W = ACC_W + 5;
    localparam int Q_W  = RPROD_W - COEFF_FRAC;

    localparam logic [LEN_W-1:0]         LEN_MAX = LEN_W'(MAX_BLOCK_LEN);
    localparam logic signed [ACC_W-1:0]  ACC_POS = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_NEG = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration registers
    logic signed [COEFF_W-1:0] coeff_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [POWER_W-1:0]        thr_reg;

    // recurrence state
    logic signed [ACC_W-1:0]   s1_reg;
    logic signed [ACC_W-1:0]   s2_reg;
    logic [LEN_W-1:0]          cnt_reg;
    logic                      flag_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    // block-end working registers
    logic signed [MCAND_W-1:0] t_reg;
    logic [POWER_W-1:0]        power_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_tone_reg;
    logic [POWER_W-1:0]        out_power_reg;

    gtd_ctl_t                  ctl;
    logic signed [PROD_W-1:0]  acc;
    logic [SER_W-1:0]          load_digits;
    logic signed [MCAND_W-1:0] mcand;

    logic                      accept;
    logic                      out_free;
    logic                      block_end;
    logic [LEN_W-1:0]          len_eff;
    logic [LEN_W-1:0]          cnt_inc;

    logic signed [Q_W-1:0]     q;
    logic signed [S0_W-1:0]    s0;
    logic signed [ACC_W-1:0]   s0_sat;
    logic [S0_W-ACC_W:0]       s0_top;

    logic signed [MCAND_W-1:0] s1_w;
    logic signed [MCAND_W-1:0] s2_w;
    logic signed [MCAND_W-1:0] cross_w;
    logic signed [MCAND_W-1:0] t_next;
    logic [POWER_W-1:0]        power_next;
    logic [POWER_W-1:0]        off_thr;
    logic                      flag_next;

    // digits of both accumulators woven together, s1 digit ahead of s2 digit
    function automatic logic [SER_W-1:0] weave(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
        logic [SER_W-1:0] w;
        w = '0;
        for (int i = 0; i < ACC_DIG; i++)
        begin
            w[SER_W-1-2*DIGIT_W*i -: DIGIT_W]           = a[ACC_W-1-DIGIT_W*i -: DIGIT_W];
            w[SER_W-1-2*DIGIT_W*i-DIGIT_W -: DIGIT_W]   = b[ACC_W-1-DIGIT_W*i -: DIGIT_W];
        end
        return w;
    endfunction

    gtd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pcm.valid),
        .block_end (block_end),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    gtd_mac u_mac
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .load_digits (load_digits),
        .mcand       (mcand),
        .acc         (acc)
    );

    assign pcm.ready = ctl.in_ready;
    assign accept    = pcm.valid & ctl.in_ready;
    assign out_free  = ~out_valid_reg | report.ready;

    // block length with zero read as one and the top capped
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LEN_W'(1);
        else if (len_reg > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = len_reg;
    end

    assign cnt_inc   = cnt_reg + 1'b1;
    assign block_end = (cnt_inc >= len_eff);

    // operand selection for the shared unit
    assign s1_w = MCAND_W'(s1_reg);
    assign s2_w = MCAND_W'(s2_reg);

    always_comb
    begin
        case (ctl.mc_sel)
            MC_S1:   mcand = s1_w;
            MC_S2:   mcand = s2_w;
            MC_T:    mcand = t_reg;
            MC_U:    mcand = s2_w <<< COEFF_FRAC;
            MC_THR:  mcand = {{(MCAND_W-POWER_W){1'b0}}, thr_reg};
            default: mcand = s1_w;
        endcase
    end

    always_comb
    begin
        case (ctl.load_sel)
            LD_COEFF: load_digits = {COEFF_SER_W'(coeff_reg), {(SER_W-COEFF_SER_W){1'b0}}};
            LD_PAIR:  load_digits = weave(s1_reg, s2_reg);
            LD_SCALE: load_digits = {OFF_SCALE, {(SER_W-COEFF_SER_W){1'b0}}};
            default:  load_digits = '0;
        endcase
    end

    // recurrence update: floor of coeff*s1 / 2^14, then saturate
    assign q      = acc[RPROD_W-1:COEFF_FRAC];
    assign s0     = S0_W'(sample_reg) + S0_W'(q) - S0_W'(s2_reg);
    assign s0_top = s0[S0_W-1:ACC_W-1];

    always_comb
    begin
        if ((&s0_top) || !(|s0_top))
            s0_sat = s0[ACC_W-1:0];
        else if (s0[S0_W-1])
            s0_sat = ACC_NEG;
        else
            s0_sat = ACC_POS;
    end

    // t = 2^14*s1 - coeff*s2, so that power = s1*t + s2*(2^14*s2)
    assign cross_w = acc[MCAND_W-1:0];
    assign t_next  = (s1_w <<< COEFF_FRAC) - cross_w;

    // power shifted right by 46, negative to zero, large to all ones
    always_comb
    begin
        if (acc[PROD_W-1])
            power_next = '0;
        else if (|acc[PROD_W-2:POWER_SHIFT+POWER_W])
            power_next = '1;
        else
            power_next = acc[POWER_SHIFT+POWER_W-1:POWER_SHIFT];
    end

    // off threshold is on*45875 / 2^16
    assign off_thr = acc[OFF_SHIFT+POWER_W-1:OFF_SHIFT];

    always_comb
    begin
        if (flag_reg)
            flag_next = ~(power_reg < off_thr);
        else
            flag_next = (power_reg >= thr_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
            len_reg   <= LEN_W'(205);
            thr_reg   <= POWER_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEFF:     coeff_reg <= cfg_data[COEFF_W-1:0];
                CFG_BLOCK_LEN: len_reg   <= cfg_data[LEN_W-1:0];
                CFG_ON_THR:    thr_reg   <= cfg_data[POWER_W-1:0];
                default:       ;
            endcase
        end
    end

    // recurrence state, block count and hysteresis flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else if (accept && pcm.restart)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else if (ctl.do_sum)
        begin
            s2_reg  <= s1_reg;
            s1_reg  <= s0_sat;
            cnt_reg <= cnt_inc;
        end
        else if (ctl.do_decide)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            cnt_reg  <= '0;
            flag_reg <= flag_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= pcm.sample;
        if (ctl.do_term)
            t_reg <= t_next;
        if (ctl.do_clamp)
            power_reg <= power_next;
        if (ctl.do_decide)
        begin
            out_tone_reg  <= flag_next;
            out_power_reg <= power_reg;
        end
    end

    // result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.do_decide)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    assign report.valid       = out_valid_reg;
    assign report.tone_on     = out_tone_reg;
    assign report.block_power = out_power_reg;

endmodule

// ===== design/gtd_mac.sv =====
// digit-serial multiply-accumulate unit shared by recurrence, power and threshold
module gtd_mac import gtd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gtd_ctl_t                  ctl,
    input  logic [SER_W-1:0]          load_digits,
    input  logic signed [MCAND_W-1:0] mcand,
    output logic signed [PROD_W-1:0]  acc
);

    logic [SER_W-1:0]         dig_reg;
    logic [SER_W-1:0]         dig_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic [DIGIT_W-1:0]       digit;
    logic signed [DIGIT_W:0]  digit_ext;
    logic signed [PP_W-1:0]   pp;
    logic signed [PROD_W-1:0] acc_base;

    // most significant digit first, horner style
    assign digit     = dig_reg[SER_W-1 -: DIGIT_W];
    assign digit_ext = ctl.digit_signed ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
    assign pp        = mcand * digit_ext;
    assign acc_base  = ctl.acc_shift ? (acc_reg <<< DIGIT_W) : acc_reg;

    always_comb
    begin
        dig_next = dig_reg;
        acc_next = acc_reg;
        if (ctl.mac_load)
        begin
            dig_next = load_digits;
            acc_next = '0;
        end
        else if (ctl.mac_step)
        begin
            dig_next = dig_reg << DIGIT_W;
            acc_next = acc_base + PROD_W'(pp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            dig_reg <= dig_next;
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== design/gtd_ctrl.sv =====
// sequencer for one sample: recurrence, and at block end power and hysteresis
module gtd_ctrl import gtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     block_end,
    input  logic     out_free,
    output gtd_ctl_t ctl
);

    gtd_state_t        state_reg;
    gtd_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        ctl.in_ready     = 1'b0;
        ctl.mac_load     = 1'b0;
        ctl.load_sel     = LD_COEFF;
        ctl.mac_step     = 1'b0;
        ctl.acc_shift    = 1'b1;
        ctl.digit_signed = 1'b0;
        ctl.mc_sel       = MC_S1;
        ctl.do_sum       = 1'b0;
        ctl.do_term      = 1'b0;
        ctl.do_clamp     = 1'b0;
        ctl.do_decide    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.mac_load = 1'b1;
                    ctl.load_sel = LD_COEFF;
                    step_next    = '0;
                    state_next   = ST_REC;
                end
            end
            ST_REC, ST_CROSS, ST_OFF:
            begin
                ctl.mac_step     = 1'b1;
                ctl.digit_signed = (step_reg == '0);
                if (state_reg == ST_REC)
                    ctl.mc_sel = MC_S1;
                else if (state_reg == ST_CROSS)
                    ctl.mc_sel = MC_S2;
                else
                    ctl.mc_sel = MC_THR;
                if (step_reg == COEFF_LAST)
                begin
                    step_next = '0;
                    if (state_reg == ST_REC)
                        state_next = ST_SUM;
                    else if (state_reg == ST_CROSS)
                        state_next = ST_TERM;
                    else
                        state_next = ST_DECIDE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SUM:
            begin
                ctl.do_sum = 1'b1;
                if (block_end)
                begin
                    ctl.mac_load = 1'b1;
                    ctl.load_sel = LD_COEFF;
                    state_next   = ST_CROSS;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_TERM:
            begin
                ctl.do_term  = 1'b1;
                ctl.mac_load = 1'b1;
                ctl.load_sel = LD_PAIR;
                state_next   = ST_POWER;
            end
            ST_POWER:
            begin
                // digits alternate between the two operands, shift only on the first
                ctl.mac_step     = 1'b1;
                ctl.acc_shift    = ~step_reg[0];
                ctl.digit_signed = (step_reg[STEP_W-1:1] == '0);
                ctl.mc_sel       = step_reg[0] ? MC_U : MC_T;
                if (step_reg == PAIR_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_CLAMP;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_CLAMP:
            begin
                ctl.do_clamp = 1'b1;
                ctl.mac_load = 1'b1;
                ctl.load_sel = LD_SCALE;
                state_next   = ST_OFF;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    ctl.do_decide = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

endmodule
